@@ rtl/graded_grid_coordinate_remap_macros.svh @@
// ---------------------------------------------------------------------------
// Graded grid coordinate remap: assertion macros
// Shared property forms for the port checker.
// ---------------------------------------------------------------------------
`ifndef GRADED_GRID_COORDINATE_REMAP_MACROS_SVH
`define GRADED_GRID_COORDINATE_REMAP_MACROS_SVH

// same-cycle implication
`define GGCR_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ggcr port check failed");

// next-cycle implication
`define GGCR_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ggcr port check failed");

`endif

@@ rtl/ggcr_pkg.sv @@
// ---------------------------------------------------------------------------
// Graded grid coordinate remap: package
// Widths, codes, stage map and pipeline word types.
// ---------------------------------------------------------------------------
package ggcr_pkg;

   localparam int MaxElements = 4096;
   localparam int CountW      = 13;
   localparam int FracW       = 16;
   localparam int QaW         = CountW + FracW;
   localparam int NumW        = 44;
   localparam int DvdaW       = NumW + FracW;
   localparam int MW          = 24;
   localparam int KsW         = 44;
   localparam int AW          = 44;
   localparam int AHalf       = 22;
   localparam int PartW       = 46;
   localparam int ProdW       = 68;
   localparam int MagW        = 45;
   localparam int PW          = 48;
   localparam int ResW        = 50;

   // stage map
   localparam int STG_PREP    = 0;
   localparam int STG_MUL     = 1;
   localparam int STG_DIVA    = 2;
   localparam int DIVA_STEPS  = DvdaW;
   localparam int STG_CLASS   = STG_DIVA + DIVA_STEPS;
   localparam int STG_PROD    = STG_CLASS + 1;
   localparam int STG_PART    = STG_PROD + 1;
   localparam int STG_SUM     = STG_PART + 1;
   localparam int STG_DIVB    = STG_SUM + 1;
   localparam int DIVB_STEPS  = AW;
   localparam int STG_ROUND   = STG_DIVB + DIVB_STEPS;
   localparam int STG_GRADE   = STG_ROUND + 1;
   localparam int STG_OFF     = STG_GRADE + 1;
   localparam int STG_FINAL   = STG_OFF + 1;
   localparam int NumStages   = STG_FINAL + 1;

   typedef enum logic [2:0] {
      EDGE_LEFT   = 3'd0,
      EDGE_RIGHT  = 3'd1,
      EDGE_TOP    = 3'd2,
      EDGE_BOTTOM = 3'd3,
      EDGE_FRONT  = 3'd4,
      EDGE_BACK   = 3'd5
   } edge_type;

   typedef enum logic [2:0] {
      REG_EDGE  = 3'd0,
      REG_MIN   = 3'd1,
      REG_MAX   = 3'd2,
      REG_FIRST = 3'd3,
      REG_COUNT = 3'd4,
      REG_TOL   = 3'd5
   } reg_index_type;

   typedef enum logic [1:0] {
      AXIS_X = 2'd0,
      AXIS_Y = 2'd1,
      AXIS_Z = 2'd2
   } axis_type;

   typedef struct packed {
      logic signed [31:0] cx;
      logic signed [31:0] cy;
      logic signed [31:0] cz;
      logic [31:0]        ud;
      logic               inr;
      logic               wbad;
      logic [DvdaW-1:0]   dvda;
      logic [31:0]        rema;
      logic [QaW-1:0]     qa;
      logic               vert;
      logic               err;
      logic               chg;
      logic [CountW-1:0]  k0;
      logic [CountW-1:0]  k1;
      logic [MW-1:0]      m0;
      logic [MW-1:0]      m1;
      logic [KsW-1:0]     ks0;
      logic [KsW-1:0]     ks1;
      logic [PartW-1:0]   pl0;
      logic [PartW-1:0]   ph0;
      logic [PartW-1:0]   pl1;
      logic [PartW-1:0]   ph1;
      logic [MW-1:0]      rb0;
      logic [MW-1:0]      rb1;
      logic [AW-1:0]      dvb0;
      logic [AW-1:0]      dvb1;
      logic [AW-1:0]      qb0;
      logic [AW-1:0]      qb1;
      logic [MagW-1:0]    mg0;
      logic [MagW-1:0]    mg1;
      logic [PW-1:0]      p0;
      logic [PW-1:0]      p1;
      logic [PW-1:0]      off;
   } ctx_type;

   typedef struct packed {
      logic signed [31:0] new_x;
      logic signed [31:0] new_y;
      logic signed [31:0] new_z;
      logic               order_error;
   } rsp_type;

endpackage

@@ rtl/ggcr_req_if.sv @@
// ---------------------------------------------------------------------------
// Graded grid coordinate remap: node channel
// Valid/ready channel carrying one grid node word.
// ---------------------------------------------------------------------------
interface ggcr_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] coord_x;
   logic signed [31:0] coord_y;
   logic signed [31:0] coord_z;

   modport source (output valid, output coord_x, output coord_y, output coord_z,
                   input ready);
   modport sink   (input valid, input coord_x, input coord_y, input coord_z,
                   output ready);
endinterface

@@ rtl/ggcr_rsp_if.sv @@
// ---------------------------------------------------------------------------
// Graded grid coordinate remap: result channel
// Valid/ready channel carrying one remapped node word.
// ---------------------------------------------------------------------------
interface ggcr_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] new_x;
   logic signed [31:0] new_y;
   logic signed [31:0] new_z;
   logic               order_error;

   modport source (output valid, output new_x, output new_y, output new_z,
                   output order_error, input ready);
   modport sink   (input valid, input new_x, input new_y, input new_z,
                   input order_error, output ready);
endinterface

@@ rtl/graded_grid_coordinate_remap.sv @@
// ---------------------------------------------------------------------------
// Graded grid coordinate remap
// Moves grid nodes along the refined axis to arithmetically graded positions.
// ---------------------------------------------------------------------------
// Usage:
//   req_bus carries one node word (coord_x/y/z, Q16.16) per valid/ready
//   handshake; rsp_bus returns one word per node, in order, with the moved
//   coordinates and order_error.
//   Registers sit on the APB port (psel/penable/pwrite/paddr/pwdata),
//   register i at byte address 4*i; write them only while the block is idle.
//   On the way from accept to rsp_bus.valid, a 60-step restoring
//   divider finds the fractional element index, and a two-lane 44-step
//   divider forms the exact rounded grading terms.
//   Throughput is one node per cycle while the receiver does not stall.
//   Reset (synchronous) empties the pipeline and loads register defaults.
//   When the receiver stalls, one more word lands in a skid slot; after
//   that req_bus.ready drops and the whole pipeline holds.
// ---------------------------------------------------------------------------
module graded_grid_coordinate_remap (
   input  logic        clock,
   input  logic        reset,
   ggcr_req_if.sink    req_bus,
   ggcr_rsp_if.source  rsp_bus,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [4:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   localparam int NS = ggcr_pkg::NumStages;

   // registers
   logic [2:0]         edge_ff;
   logic signed [31:0] min_ff;
   logic signed [31:0] max_ff;
   logic [30:0]        first_ff;
   logic [12:0]        count_ff;
   logic [14:0]        tol_ff;

   // derived configuration
   logic [1:0]         axis_sel;
   logic               at_min;
   logic [32:0]        span;
   logic               span_bad;
   logic [12:0]        n_cl;
   logic signed [31:0] base;
   logic [25:0]        dd_full;
   logic [43:0]        ns_in;
   logic [43:0]        ns_ff;
   logic [23:0]        dd_ff;
   logic [44:0]        a_val;
   logic [44:0]        a_negv;
   logic [43:0]        a_abs_ff;
   logic               a_neg_ff;

   // pipeline
   ggcr_pkg::ctx_type ctx_ff [NS];
   ggcr_pkg::ctx_type nxt_arr [NS-1];
   ggcr_pkg::ctx_type in_ctx;
   logic [NS-1:0]     v_ff;
   logic              en_g;

   // output side
   ggcr_pkg::rsp_type fin;
   ggcr_pkg::rsp_type out_ff;
   ggcr_pkg::rsp_type skid_ff;
   logic              out_v_ff;
   logic              skid_v_ff;

   // ---------------- register file ----------------
   assign pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         edge_ff  <= ggcr_pkg::EDGE_LEFT;
         min_ff   <= 32'sd0;
         max_ff   <= 32'sd65536;
         first_ff <= 31'd4096;
         count_ff <= 13'd16;
         tol_ff   <= 15'd1;
      end else if (psel && penable && pwrite) begin
         case (ggcr_pkg::reg_index_type'(paddr[4:2]))
            ggcr_pkg::REG_EDGE:  edge_ff  <= pwdata[2:0];
            ggcr_pkg::REG_MIN:   min_ff   <= pwdata;
            ggcr_pkg::REG_MAX:   max_ff   <= pwdata;
            ggcr_pkg::REG_FIRST: first_ff <= pwdata[30:0];
            ggcr_pkg::REG_COUNT: count_ff <= pwdata[12:0];
            ggcr_pkg::REG_TOL:   tol_ff   <= pwdata[14:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (ggcr_pkg::reg_index_type'(paddr[4:2]))
         ggcr_pkg::REG_EDGE:  prdata = {29'd0, edge_ff};
         ggcr_pkg::REG_MIN:   prdata = min_ff;
         ggcr_pkg::REG_MAX:   prdata = max_ff;
         ggcr_pkg::REG_FIRST: prdata = {1'b0, first_ff};
         ggcr_pkg::REG_COUNT: prdata = {19'd0, count_ff};
         ggcr_pkg::REG_TOL:   prdata = {17'd0, tol_ff};
         default:             prdata = 32'd0;
      endcase
   end

   // ---------------- derived configuration ----------------
   always_comb begin
      if (edge_ff <= ggcr_pkg::EDGE_RIGHT)       axis_sel = ggcr_pkg::AXIS_X;
      else if (edge_ff <= ggcr_pkg::EDGE_BOTTOM) axis_sel = ggcr_pkg::AXIS_Y;
      else                                       axis_sel = ggcr_pkg::AXIS_Z;
      at_min = (edge_ff == ggcr_pkg::EDGE_LEFT) || (edge_ff == ggcr_pkg::EDGE_BOTTOM)
               || (edge_ff >= ggcr_pkg::EDGE_BACK);
      span     = {max_ff[31], max_ff} - {min_ff[31], min_ff};
      span_bad = span[32] || (span == 33'd0);
      if (count_ff < 13'd2)                                  n_cl = 13'd2;
      else if (count_ff > 13'(ggcr_pkg::MaxElements))        n_cl = 13'(ggcr_pkg::MaxElements);
      else                                                   n_cl = count_ff;
      base    = at_min ? min_ff : max_ff;
      dd_full = {13'd0, n_cl} * ({13'd0, n_cl} - 26'd1);
      ns_in   = {31'd0, n_cl} * {13'd0, first_ff};
      a_val   = {{12{span[32]}}, span} - {1'b0, ns_ff};
      a_negv  = 45'd0 - a_val;
   end

   always_ff @(posedge clock) begin
      ns_ff    <= ns_in;
      dd_ff    <= dd_full[23:0];
      a_neg_ff <= a_val[44];
      a_abs_ff <= a_val[44] ? a_negv[43:0] : a_val[43:0];
   end

   // ---------------- pipeline control ----------------
   assign en_g          = !skid_v_ff;
   assign req_bus.ready = en_g;

   always_comb begin
      in_ctx    = '0;
      in_ctx.cx = req_bus.coord_x;
      in_ctx.cy = req_bus.coord_y;
      in_ctx.cz = req_bus.coord_z;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en_g) begin
         v_ff <= {v_ff[NS-2:0], req_bus.valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en_g) begin
         ctx_ff[0] <= in_ctx;
         for (int j = 0; j < NS - 1; j++) begin
            ctx_ff[j+1] <= nxt_arr[j];
         end
      end
   end

   // ---------------- stages ----------------
   for (genvar j = 0; j < NS - 1; j++) begin : g_stage
      if (j == ggcr_pkg::STG_PREP) begin : g_prep
         logic signed [31:0] c_sel;
         logic [32:0]        d;
         logic [32:0]        dn;
         always_comb begin
            case (axis_sel)
               ggcr_pkg::AXIS_X: c_sel = ctx_ff[j].cx;
               ggcr_pkg::AXIS_Y: c_sel = ctx_ff[j].cy;
               default:          c_sel = ctx_ff[j].cz;
            endcase
            d  = at_min ? ({c_sel[31], c_sel} - {min_ff[31], min_ff})
                        : ({max_ff[31], max_ff} - {c_sel[31], c_sel});
            dn = 33'd0 - d;
            nxt_arr[j]      = ctx_ff[j];
            nxt_arr[j].ud   = d[32] ? dn[31:0] : d[31:0];
            nxt_arr[j].inr  = !d[32] && (d[31:0] < span[31:0]);
            nxt_arr[j].wbad = span_bad;
         end
      end else if (j == ggcr_pkg::STG_MUL) begin : g_mul
         logic [44:0] num;
         always_comb begin
            num             = {13'd0, ctx_ff[j].ud} * {32'd0, n_cl};
            nxt_arr[j]      = ctx_ff[j];
            nxt_arr[j].dvda = {num[43:0], 16'd0};
            nxt_arr[j].rema = 32'd0;
            nxt_arr[j].qa   = '0;
         end
      end else if (j < ggcr_pkg::STG_CLASS) begin : g_diva
         logic [32:0] r2;
         logic [33:0] df;
         always_comb begin
            r2              = {ctx_ff[j].rema, ctx_ff[j].dvda[ggcr_pkg::DvdaW-1]};
            df              = {1'b0, r2} - {2'b0, span[31:0]};
            nxt_arr[j]      = ctx_ff[j];
            nxt_arr[j].rema = df[33] ? r2[31:0] : df[31:0];
            nxt_arr[j].dvda = {ctx_ff[j].dvda[ggcr_pkg::DvdaW-2:0], 1'b0};
            nxt_arr[j].qa   = {ctx_ff[j].qa[ggcr_pkg::QaW-2:0], !df[33]};
         end
      end else if (j == ggcr_pkg::STG_CLASS) begin : g_class
         logic [12:0] q;
         logic [15:0] f;
         logic [15:0] dm;
         logic [16:0] comp;
         logic        lo_hit;
         logic        hi_hit;
         logic        mid_hit;
         logic        vert;
         logic [12:0] k0;
         always_comb begin
            q       = ctx_ff[j].qa[28:16];
            f       = ctx_ff[j].qa[15:0];
            comp    = 17'h10000 - {1'b0, f};
            dm      = f[15] ? {1'b0, f[14:0]} : (16'h8000 - f);
            lo_hit  = {1'b0, f} < {2'b0, tol_ff};
            hi_hit  = comp < {2'b0, tol_ff};
            mid_hit = {1'b0, dm} < {2'b0, tol_ff};
            vert    = lo_hit || hi_hit;
            k0      = (vert && !lo_hit) ? (q + 13'd1) : q;
            nxt_arr[j]      = ctx_ff[j];
            nxt_arr[j].vert = vert;
            nxt_arr[j].k0   = k0;
            nxt_arr[j].k1   = q + 13'd1;
            nxt_arr[j].err  = ctx_ff[j].wbad || (!vert && !mid_hit);
            nxt_arr[j].chg  = !ctx_ff[j].wbad && ctx_ff[j].inr &&
                              (vert ? ((k0 != 13'd0) && (k0 < n_cl)) : mid_hit);
         end
      end else if (j == ggcr_pkg::STG_PROD) begin : g_prod
         logic [25:0] t0;
         logic [25:0] t1;
         always_comb begin
            t0 = {13'd0, ctx_ff[j].k0} * ({13'd0, ctx_ff[j].k0} - 26'd1);
            t1 = {13'd0, ctx_ff[j].k1} * ({13'd0, ctx_ff[j].k1} - 26'd1);
            nxt_arr[j]     = ctx_ff[j];
            nxt_arr[j].m0  = (ctx_ff[j].k0 == 13'd0) ? 24'd0 : t0[23:0];
            nxt_arr[j].m1  = (ctx_ff[j].k1 == 13'd0) ? 24'd0 : t1[23:0];
            nxt_arr[j].ks0 = {31'd0, ctx_ff[j].k0} * {13'd0, first_ff};
            nxt_arr[j].ks1 = {31'd0, ctx_ff[j].k1} * {13'd0, first_ff};
         end
      end else if (j == ggcr_pkg::STG_PART) begin : g_part
         always_comb begin
            nxt_arr[j]     = ctx_ff[j];
            nxt_arr[j].pl0 = {24'd0, a_abs_ff[21:0]} * {22'd0, ctx_ff[j].m0};
            nxt_arr[j].ph0 = {24'd0, a_abs_ff[43:22]} * {22'd0, ctx_ff[j].m0};
            nxt_arr[j].pl1 = {24'd0, a_abs_ff[21:0]} * {22'd0, ctx_ff[j].m1};
            nxt_arr[j].ph1 = {24'd0, a_abs_ff[43:22]} * {22'd0, ctx_ff[j].m1};
         end
      end else if (j == ggcr_pkg::STG_SUM) begin : g_sum
         logic [67:0] s0;
         logic [67:0] s1;
         always_comb begin
            s0 = {ctx_ff[j].ph0, 22'd0} + {22'd0, ctx_ff[j].pl0};
            s1 = {ctx_ff[j].ph1, 22'd0} + {22'd0, ctx_ff[j].pl1};
            nxt_arr[j]      = ctx_ff[j];
            nxt_arr[j].rb0  = s0[67:44];
            nxt_arr[j].dvb0 = s0[43:0];
            nxt_arr[j].rb1  = s1[67:44];
            nxt_arr[j].dvb1 = s1[43:0];
            nxt_arr[j].qb0  = '0;
            nxt_arr[j].qb1  = '0;
         end
      end else if (j < ggcr_pkg::STG_ROUND) begin : g_divb
         logic [24:0] r0;
         logic [24:0] r1;
         logic [25:0] d0;
         logic [25:0] d1;
         always_comb begin
            r0 = {ctx_ff[j].rb0, ctx_ff[j].dvb0[43]};
            r1 = {ctx_ff[j].rb1, ctx_ff[j].dvb1[43]};
            d0 = {1'b0, r0} - {2'b0, dd_ff};
            d1 = {1'b0, r1} - {2'b0, dd_ff};
            nxt_arr[j]      = ctx_ff[j];
            nxt_arr[j].rb0  = d0[25] ? r0[23:0] : d0[23:0];
            nxt_arr[j].rb1  = d1[25] ? r1[23:0] : d1[23:0];
            nxt_arr[j].dvb0 = {ctx_ff[j].dvb0[42:0], 1'b0};
            nxt_arr[j].dvb1 = {ctx_ff[j].dvb1[42:0], 1'b0};
            nxt_arr[j].qb0  = {ctx_ff[j].qb0[42:0], !d0[25]};
            nxt_arr[j].qb1  = {ctx_ff[j].qb1[42:0], !d1[25]};
         end
      end else if (j == ggcr_pkg::STG_ROUND) begin : g_round
         always_comb begin
            nxt_arr[j]     = ctx_ff[j];
            nxt_arr[j].mg0 = {1'b0, ctx_ff[j].qb0} +
                             45'({ctx_ff[j].rb0, 1'b0} >= {1'b0, dd_ff});
            nxt_arr[j].mg1 = {1'b0, ctx_ff[j].qb1} +
                             45'({ctx_ff[j].rb1, 1'b0} >= {1'b0, dd_ff});
         end
      end else if (j == ggcr_pkg::STG_GRADE) begin : g_grade
         logic [47:0] g0;
         logic [47:0] g1;
         always_comb begin
            g0 = a_neg_ff ? (48'd0 - {3'd0, ctx_ff[j].mg0}) : {3'd0, ctx_ff[j].mg0};
            g1 = a_neg_ff ? (48'd0 - {3'd0, ctx_ff[j].mg1}) : {3'd0, ctx_ff[j].mg1};
            nxt_arr[j]    = ctx_ff[j];
            nxt_arr[j].p0 = {4'd0, ctx_ff[j].ks0} + g0;
            nxt_arr[j].p1 = {4'd0, ctx_ff[j].ks1} + g1;
         end
      end else begin : g_off
         logic [48:0] sm;
         always_comb begin
            sm = {ctx_ff[j].p0[47], ctx_ff[j].p0} + {ctx_ff[j].p1[47], ctx_ff[j].p1};
            nxt_arr[j]     = ctx_ff[j];
            nxt_arr[j].off = ctx_ff[j].vert ? ctx_ff[j].p0 : sm[48:1];
         end
      end
   end

   // final stage: place the graded coordinate and saturate
   logic [49:0] res;
   logic [31:0] sat;
   always_comb begin
      res = at_min ? ({{18{base[31]}}, base} + {{2{ctx_ff[NS-1].off[47]}}, ctx_ff[NS-1].off})
                   : ({{18{base[31]}}, base} - {{2{ctx_ff[NS-1].off[47]}}, ctx_ff[NS-1].off});
      if (!res[49] && (res[48:31] != 18'd0))      sat = 32'h7fff_ffff;
      else if (res[49] && (res[48:31] != '1))     sat = 32'h8000_0000;
      else                                        sat = res[31:0];
      fin.new_x       = ctx_ff[NS-1].cx;
      fin.new_y       = ctx_ff[NS-1].cy;
      fin.new_z       = ctx_ff[NS-1].cz;
      fin.order_error = ctx_ff[NS-1].err;
      if (ctx_ff[NS-1].chg) begin
         case (axis_sel)
            ggcr_pkg::AXIS_X: fin.new_x = sat;
            ggcr_pkg::AXIS_Y: fin.new_y = sat;
            default:          fin.new_z = sat;
         endcase
      end
   end

   // ---------------- output register and skid slot ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else if (out_v_ff && !rsp_bus.ready) begin
         if (v_ff[NS-1] && en_g) begin
            skid_v_ff <= 1'b1;
         end
      end else if (skid_v_ff) begin
         out_v_ff  <= 1'b1;
         skid_v_ff <= 1'b0;
      end else begin
         out_v_ff <= v_ff[NS-1] && en_g;
      end
   end

   always_ff @(posedge clock) begin
      if (out_v_ff && !rsp_bus.ready) begin
         if (v_ff[NS-1] && en_g) begin
            skid_ff <= fin;
         end
      end else if (skid_v_ff) begin
         out_ff <= skid_ff;
      end else begin
         out_ff <= fin;
      end
   end

   assign rsp_bus.valid       = out_v_ff;
   assign rsp_bus.new_x       = out_ff.new_x;
   assign rsp_bus.new_y       = out_ff.new_y;
   assign rsp_bus.new_z       = out_ff.new_z;
   assign rsp_bus.order_error = out_ff.order_error;

endmodule

@@ rtl/ggcr_checker.sv @@
// ---------------------------------------------------------------------------
// Graded grid coordinate remap: port checker
// Watches the handshake ports of the top level over time.
// ---------------------------------------------------------------------------
`include "graded_grid_coordinate_remap_macros.svh"

module ggcr_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready
);

   // backpressure on the node side only comes from a stalled result word
   `GGCR_ASSERT_NOW(a_ready_low_needs_rsp, clock, reset, !req_ready, rsp_valid)
   `GGCR_ASSERT_NOW(a_ready_low_after_stall, clock, reset, !req_ready, $past(rsp_valid && !rsp_ready))
   `GGCR_ASSERT_NOW(a_empty_after_reset, clock, reset, $past(reset), !rsp_valid && req_ready)
   `GGCR_ASSERT_NEXT(a_rsp_valid_holds, clock, reset, rsp_valid && !rsp_ready, rsp_valid)

   logic unused_req_valid;
   assign unused_req_valid = req_valid;

endmodule

bind graded_grid_coordinate_remap ggcr_checker u_ggcr_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_bus.valid),
   .req_ready (req_bus.ready),
   .rsp_valid (rsp_bus.valid),
   .rsp_ready (rsp_bus.ready)
);
